>>> sv/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and helpers for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_BITS_DEF  = 32;
  // double dabble shift steps done in one pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam int DEC_BASE        = 10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // number of decimal digits of 2^(bits-1), the largest magnitude
  function automatic int dec_digits(input int bits);
    logic [63:0] p;
    int          n;
    p = 64'd1 << (bits - 1);
    n = 0;
    while (p != 64'd0) begin
      p = p / 64'(DEC_BASE);
      n++;
    end
    return n;
  endfunction

endpackage

>>> sv/sitda_if.sv
// ----------------------------------------------------------------------------
// sitda_if
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
interface sitda_in_if #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

>>> sv/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed integer in, decimal ASCII text out, one character per word.
// ----------------------------------------------------------------------------
//  channel  dir  fields               word
//  in_ch    in   value[VALUE_BITS]    one integer
//  out_ch   out  ascii_char[8], last  one character, last on final digit
//
//  Pipeline: sign/magnitude register, then ceil(VALUE_BITS/4) double dabble
//  stages (4 shift steps each), then the character serializer.
//  The serializer loads a number, then gives one character per cycle while out_ch
//  is ready; a new number loads after the last character. This sets the sustained rate.
//  First character path: sign/magnitude, dabble, load and output registers.
//  rst_n is synchronous; it clears all valid and busy flags.
//  A stalled out_ch holds its word; the back pressure walks up the pipeline.
module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sitda_in_if.sink    in_ch,
  sitda_out_if.source out_ch
);

  localparam int STEPS = sitda_pkg::STEPS_PER_STAGE;
  localparam int NDIG  = sitda_pkg::dec_digits(VALUE_BITS);
  localparam int BCD_W = 4 * NDIG;
  localparam int NSTG  = (VALUE_BITS + STEPS - 1) / STEPS;

  logic                  f_v_r;
  logic                  f_neg_r;
  logic [VALUE_BITS-1:0] f_mag_r;

  logic [NSTG:0]         v_w;
  logic [NSTG:0]         r_w;
  logic [NSTG:0]         n_w;
  logic [BCD_W-1:0]      bcd_w [NSTG+1];
  logic [VALUE_BITS-1:0] bin_w [NSTG+1];

  assign in_ch.ready = !f_v_r || r_w[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      f_v_r <= in_ch.valid;
    end
  end

  // magnitude in VALUE_BITS unsigned bits covers the most negative value
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      f_neg_r <= in_ch.value[VALUE_BITS-1];
      f_mag_r <= in_ch.value[VALUE_BITS-1] ? (~in_ch.value + VALUE_BITS'(1)) : in_ch.value;
    end
  end

  assign v_w[0]   = f_v_r;
  assign n_w[0]   = f_neg_r;
  assign bcd_w[0] = '0;
  assign bin_w[0] = f_mag_r;

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    sitda_dabble_stage #(
      .VALUE_BITS (VALUE_BITS),
      .BCD_W      (BCD_W),
      .STEP_BASE  (g * STEPS),
      .STEPS      (STEPS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v_w[g]),
      .up_ready (r_w[g]),
      .up_neg   (n_w[g]),
      .up_bcd   (bcd_w[g]),
      .up_bin   (bin_w[g]),
      .dn_valid (v_w[g+1]),
      .dn_ready (r_w[g+1]),
      .dn_neg   (n_w[g+1]),
      .dn_bcd   (bcd_w[g+1]),
      .dn_bin   (bin_w[g+1])
    );
  end

  sitda_serializer #(
    .BCD_W (BCD_W)
  ) u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v_w[NSTG]),
    .in_ready (r_w[NSTG]),
    .in_neg   (n_w[NSTG]),
    .in_bcd   (bcd_w[NSTG]),
    .out_ch   (out_ch)
  );

endmodule

>>> sv/sitda_dabble_stage.sv
// ----------------------------------------------------------------------------
// sitda_dabble_stage
// One registered pipeline stage doing a few binary to BCD shift-add-3 steps.
// ----------------------------------------------------------------------------
module sitda_dabble_stage #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF,
  parameter int BCD_W      = 4 * sitda_pkg::dec_digits(sitda_pkg::VALUE_BITS_DEF),
  parameter int STEP_BASE  = 0,
  parameter int STEPS      = sitda_pkg::STEPS_PER_STAGE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic                  up_neg,
  input  logic [BCD_W-1:0]      up_bcd,
  input  logic [VALUE_BITS-1:0] up_bin,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic                  dn_neg,
  output logic [BCD_W-1:0]      dn_bcd,
  output logic [VALUE_BITS-1:0] dn_bin
);

  localparam int NDIG = BCD_W / 4;

  logic                  valid_r;
  logic                  neg_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [VALUE_BITS-1:0] bin_r;
  logic [BCD_W-1:0]      bcd_nxt;
  logic [VALUE_BITS-1:0] bin_nxt;

  always_comb begin
    bcd_nxt = up_bcd;
    bin_nxt = up_bin;
    for (int s = 0; s < STEPS; s++) begin
      // last stage may run past the final step
      if (STEP_BASE + s < VALUE_BITS) begin
        for (int d = 0; d < NDIG; d++) begin
          if (bcd_nxt[d*4 +: 4] >= 4'd5) begin
            bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
          end
        end
        bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[VALUE_BITS-1]};
        bin_nxt = {bin_nxt[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      neg_r <= up_neg;
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_neg   = neg_r;
  assign dn_bcd   = bcd_r;
  assign dn_bin   = bin_r;

endmodule

>>> sv/sitda_serializer.sv
// ----------------------------------------------------------------------------
// sitda_serializer
// Turns one BCD number into a minus word, if negative, and digit words, one word per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module sitda_serializer #(
  parameter int BCD_W = 4 * sitda_pkg::dec_digits(sitda_pkg::VALUE_BITS_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_neg,
  input  logic [BCD_W-1:0] in_bcd,
  sitda_out_if.source      out_ch
);

  localparam int NDIG = BCD_W / 4;
  localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic             busy_r, busy_nxt;
  logic             neg_r, neg_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [BCD_W-1:0] digits_r, digits_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       och_r, och_nxt;
  logic             olast_r, olast_nxt;
  logic [IW-1:0]    top_idx;
  logic [3:0]       cur_digit;
  logic             slot_free;

  // highest nonzero digit; zero gives index 0 and a single '0'
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (in_bcd[d*4 +: 4] != 4'd0) begin
        top_idx = IW'(d);
      end
    end
  end

  assign cur_digit = digits_r[idx_r*4 +: 4];
  assign slot_free = !ov_r || out_ch.ready;
  assign in_ready  = !busy_r;

  always_comb begin
    busy_nxt   = busy_r;
    neg_nxt    = neg_r;
    idx_nxt    = idx_r;
    digits_nxt = digits_r;
    ov_nxt     = ov_r;
    och_nxt    = och_r;
    olast_nxt  = olast_r;
    if (slot_free) begin
      ov_nxt = 1'b0;
    end
    if (busy_r && slot_free) begin
      ov_nxt = 1'b1;
      if (neg_r) begin
        och_nxt   = sitda_pkg::CHAR_MINUS;
        olast_nxt = 1'b0;
        neg_nxt   = 1'b0;
      end else begin
        och_nxt   = sitda_pkg::CHAR_ZERO | {4'h0, cur_digit};
        olast_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - IW'(1);
        end
      end
    end
    if (in_valid && !busy_r) begin
      busy_nxt   = 1'b1;
      neg_nxt    = in_neg;
      idx_nxt    = top_idx;
      digits_nxt = in_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      neg_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      neg_r  <= neg_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    digits_r <= digits_nxt;
    och_r    <= och_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.ascii_char = och_r;
  assign out_ch.last       = olast_r;

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (och_r == sitda_pkg::CHAR_MINUS) ||
             ((och_r >= sitda_pkg::CHAR_ZERO) && (och_r <= 8'h39)))
    else $error("illegal output character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && och_r == sitda_pkg::CHAR_MINUS) |-> !olast_r)
    else $error("sign flagged as last");

  a_sign_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    neg_r |-> busy_r)
    else $error("sign pending with no number loaded");

  a_last_ends_number: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !neg_r && idx_r == '0 && slot_free) |=> (!busy_r && ov_r && olast_r))
    else $error("final digit not flagged last");

endmodule

>>> test/sitda_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_tb_pkg
// Scoreboard for the signed integer to decimal text block: turns each
// accepted integer into its expected characters and checks the output words
// against them in order.
// ----------------------------------------------------------------------------
package sitda_tb_pkg;

  localparam int VB = sitda_pkg::VALUE_BITS_DEF;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } char_word_t;

  class decimal_text_scoreboard;
    char_word_t  text_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return text_q.size();
    endfunction

    // Expected text of one integer, sign first, then digits msd first.
    function void note_value(input logic [VB-1:0] value);
      logic          neg;
      logic [VB-1:0] mag;
      logic [3:0]    digits[$];
      char_word_t    w;
      neg = value[VB-1];
      // magnitude kept unsigned at full width so the most negative value works
      mag = neg ? (~value + VB'(1)) : value;
      do begin
        digits.push_front(4'(mag % VB'(sitda_pkg::DEC_BASE)));
        mag = mag / VB'(sitda_pkg::DEC_BASE);
      end while (mag != '0);
      if (neg) begin
        w.ascii_char = sitda_pkg::CHAR_MINUS;
        w.last       = 1'b0;
        text_q.push_back(w);
      end
      for (int k = 0; k < digits.size(); k++) begin
        w.ascii_char = sitda_pkg::CHAR_ZERO + 8'(digits[k]);
        w.last       = (k == digits.size() - 1);
        text_q.push_back(w);
      end
    endfunction

    function void check_char(input logic [7:0] ascii_char, input logic last);
      char_word_t w;
      if (text_q.size() == 0) begin
        $error("ascii_char: unexpected word %h (last %b), nothing pending", ascii_char, last);
        errors++;
        return;
      end
      w = text_q.pop_front();
      if (ascii_char !== w.ascii_char) begin
        $error("ascii_char: expected %h, actual %h", w.ascii_char, ascii_char);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %b, actual %b", w.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> test/signed_int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb
// Feeds directed and random integers into the converter with bursty input
// and a stalling receiver, and checks every output character and last flag.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_tb;

  localparam int VB           = sitda_tb_pkg::VB;
  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 240;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_DIGITS   = 10;

  localparam logic [VB-1:0] DIRECTED [20] = '{
    VB'(0), VB'(1), VB'(-1), VB'(9), VB'(10), VB'(-10), VB'(99), VB'(100),
    VB'(-9), VB'(2147483647), 32'h8000_0000, 32'h8000_0001, VB'(1000000000),
    VB'(-1000000000), VB'(999999999), VB'(123456789), VB'(-987654321),
    VB'(1000), VB'(-100000), 32'h7FFF_FFFE
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_SPARSE,
    STALL_BURSTY
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  sitda_in_if #(.VALUE_BITS(VB)) in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii_top #(.VALUE_BITS(VB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sitda_tb_pkg::decimal_text_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  // accepted words on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_value(in_ch.value);
      if (out_ch.valid && out_ch.ready) sb.check_char(out_ch.ascii_char, out_ch.last);
    end
  end

  // receiver stall pattern, switching style every so often
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          run_left   = 0;
  logic        run_ready  = 1'b1;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 200);
      run_left   = 0;
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:   out_ch.ready <= 1'b1;
      STALL_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      STALL_SPARSE: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_ready = !run_ready;
          run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(5, 30);
        end
        run_left--;
        out_ch.ready <= run_ready;
      end
    endcase
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next word can follow without a bubble.
  task automatic send_value(input logic [VB-1:0] value);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // mostly a random digit count with random sign, some raw random bits
  function automatic logic [VB-1:0] rand_value();
    int          d;
    logic        neg;
    logic [63:0] lo, hi, mag;
    if ($urandom_range(0, 3) == 0) return VB'($urandom);
    d   = $urandom_range(1, MAX_DIGITS);
    neg = 1'($urandom_range(0, 1));
    lo  = 64'd1;
    for (int k = 1; k < d; k++) lo = lo * 64'd10;
    hi = lo * 64'd10 - 64'd1;
    if (d == 1) lo = 64'd0;
    if (hi > (64'd1 << (VB - 1)) - 64'(!neg)) hi = (64'd1 << (VB - 1)) - 64'(!neg);
    mag = lo + {$urandom, $urandom} % (hi - lo + 64'd1);
    return neg ? VB'(-mag) : VB'(mag);
  endfunction

  initial begin
    int burst_left;
    int gap;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_value(DIRECTED[i]);
    in_ch.valid <= 1'b0;
    // hold off until every character of the directed part is out
    wait_drained();

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      send_value(rand_value());
      burst_left--;
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sitda_pkg.sv
sv/sitda_if.sv
sv/sitda_dabble_stage.sv
sv/sitda_serializer.sv
sv/signed_int_to_decimal_ascii_top.sv
test/sitda_tb_pkg.sv
test/signed_int_to_decimal_ascii_top_tb.sv
